@@ sv/gnz_pkg.sv @@
// ----------------------------------------------------------------------------
// gnz_pkg: shared constants and types for 2D gradient noise
// Fixed-point format, hash and fade constants, datapath word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gnz_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int OUT_W     = 19;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LIM       = 3 * ONE;
  localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN   = -(1 << (OUT_W - 1));

  localparam int HASH_X    = 57;
  localparam int HASH_Y    = 131;
  localparam int CORNER_10 = 1;
  localparam int CORNER_01 = 57;
  localparam int CORNER_11 = 58;

  localparam int FADE_A    = 6;
  localparam int FADE_B    = 15;
  localparam int FADE_C    = 10;

  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic [FRAC_BITS:0]          ease_t;
  typedef logic signed [FRAC_BITS+2:0] corner_t;
  typedef logic signed [FRAC_BITS+3:0] diff_t;
  typedef logic signed [OUT_W-1:0]     out_t;

endpackage

`default_nettype wire

@@ sv/gnz_fade.sv @@
// ----------------------------------------------------------------------------
// gnz_fade: quintic fade curve, three register stages
// Computes t*t*t*(t*(6t - 15) + 10) with floor truncation after each product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnz_fade
  import gnz_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  valid_in,
  input  wire frac_t t,
  output logic       valid_out,
  output ease_t      ease
);

  localparam int IW = FRAC_BITS + 5;

  logic                        v1;
  logic                        v2;
  frac_t                       t1;
  frac_t                       t2;
  frac_t                       t3;
  logic signed [IW-1:0]        ia1;
  logic signed [IW-1:0]        ia2;

  logic [2*FRAC_BITS-1:0]      sq;
  logic [2*FRAC_BITS-1:0]      cube;
  logic signed [IW-1:0]        inner0;
  logic signed [FRAC_BITS+IW:0] m1;
  logic signed [FRAC_BITS+IW:0] m3;
  logic signed [IW-1:0]        ia_next;

  always_comb begin
    sq      = (2*FRAC_BITS)'(t) * (2*FRAC_BITS)'(t);
    inner0  = $signed(IW'(t) * IW'(FADE_A)) - $signed(IW'(FADE_B * ONE));
    m1      = $signed({1'b0, t}) * inner0;
    ia_next = IW'(m1 >>> FRAC_BITS) + IW'(FADE_C * ONE);
    cube    = (2*FRAC_BITS)'(t2) * (2*FRAC_BITS)'(t1);
    m3      = $signed({1'b0, t3}) * ia2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1        <= valid_in;
      v2        <= v1;
      valid_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t1   <= t;
    t2   <= sq[2*FRAC_BITS-1:FRAC_BITS];
    ia1  <= ia_next;
    t3   <= cube[2*FRAC_BITS-1:FRAC_BITS];
    ia2  <= ia1;
    ease <= ease_t'(m3 >>> FRAC_BITS);
  end

  a_ease_max: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> (32'(ease) <= ONE))
    else $error("fade output above one");

  a_inner_pos: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (ia2 > 0))
    else $error("fade inner term not positive");

  a_valid_lat: assert property (@(posedge clk) disable iff (rst)
    valid_in |-> ##3 valid_out)
    else $error("fade beat lost");

endmodule

`default_nettype wire

@@ sv/gradient_noise_2d_top.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d_top: 2D gradient noise, one point per clock
// Hashed-cell gradient noise with quintic fade and bilinear blend.
// ----------------------------------------------------------------------------
// Usage:
//   Drive x_coord and y_coord (unsigned 8.16) with start high; the beat is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while rst is asserted, so a new point may be given on every cycle.
//   The result noise_value (signed 3.16) is shown for exactly one cycle with
//   done high, and is taken at the edge that ends that cycle.
//   Pipeline: an accepted point passes the input register, three fade
//   stages, two blend stages along x, difference, product and final
//   add/saturate before the result is taken.
//   Throughput: one point per cycle, set by the fully pipelined datapath;
//   no stage chains two full multipliers.
//   Reset: synchronous rst clears every valid bit; points in flight are
//   dropped and no result is given for them.
//   The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_2d_top
  import gnz_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire coord_t x_coord,
  input  wire coord_t y_coord,
  output logic        done,
  output out_t        noise_value
);

  localparam int PW = 2 * FRAC_BITS + 6;
  localparam int HW = FRAC_BITS + 5;
  localparam int QW = 2 * FRAC_BITS + 7;

  function automatic corner_t corner_grad(
    input logic [1:0]                g,
    input logic signed [FRAC_BITS:0] dx,
    input logic signed [FRAC_BITS:0] dy
  );
    corner_t p;
    corner_t q;
    corner_t r;
    p = g[1] ? corner_t'(dy) : corner_t'(dx);
    q = g[1] ? corner_t'(dx) : corner_t'(dy);
    r = g[0] ? -p : p;
    r = g[1] ? (r - (q <<< 1)) : (r + (q <<< 1));
    return r;
  endfunction

  logic                        accept;
  logic [31:0]                 xsh;
  logic [31:0]                 ysh;

  logic                        v0;
  frac_t                       fx0;
  frac_t                       fy0;
  logic [7:0]                  xi0;
  logic [7:0]                  yi0;

  logic [7:0]                  hsh;
  logic [7:0]                  h10;
  logic [7:0]                  h01;
  logic [7:0]                  h11;
  logic signed [FRAC_BITS:0]   dxp;
  logic signed [FRAC_BITS:0]   dxm;
  logic signed [FRAC_BITS:0]   dyp;
  logic signed [FRAC_BITS:0]   dym;

  corner_t                     a00_1;
  corner_t                     a10_1;
  corner_t                     a01_1;
  corner_t                     a11_1;

  corner_t                     a00_2;
  corner_t                     a01_2;
  diff_t                       d0_2;
  diff_t                       d1_2;

  corner_t                     a00_3;
  corner_t                     a01_3;
  diff_t                       d0_3;
  diff_t                       d1_3;

  logic                        vx3;
  logic                        vy3;
  ease_t                       ex3;
  ease_t                       ey3;

  logic                        v4;
  logic signed [PW-1:0]        p0_4;
  logic signed [PW-1:0]        p1_4;
  corner_t                     a00_4;
  corner_t                     a01_4;
  ease_t                       ey4;

  logic                        v5;
  diff_t                       lo5;
  diff_t                       hi5;
  ease_t                       ey5;

  logic                        v6;
  diff_t                       lo6;
  logic signed [HW-1:0]        dlh6;
  ease_t                       ey6;

  logic                        v7;
  diff_t                       lo7;
  logic signed [QW-1:0]        q7;

  logic signed [HW-1:0]        r_sum;
  logic signed [31:0]          r_wide;
  logic signed [31:0]          r_sat;
  out_t                        noise_value_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign xsh    = 32'(x_coord) >> FRAC_BITS;
  assign ysh    = 32'(y_coord) >> FRAC_BITS;

  always_comb begin
    hsh = 8'(16'(xi0) * 16'(HASH_X) + 16'(yi0) * 16'(HASH_Y));
    h10 = hsh + 8'(CORNER_10);
    h01 = hsh + 8'(CORNER_01);
    h11 = hsh + 8'(CORNER_11);
    dxp = $signed({1'b0, fx0});
    dxm = $signed({1'b1, fx0});
    dyp = $signed({1'b0, fy0});
    dym = $signed({1'b1, fy0});
  end

  always_comb begin
    r_sum  = HW'(lo7) + HW'(q7 >>> FRAC_BITS);
    r_wide = 32'(r_sum);
    r_sat  = r_wide;
    if (r_sat > LIM) begin
      r_sat = LIM;
    end
    if (r_sat < -LIM) begin
      r_sat = -LIM;
    end
    if (r_sat > OUT_MAX) begin
      r_sat = OUT_MAX;
    end
    if (r_sat < OUT_MIN) begin
      r_sat = OUT_MIN;
    end
    noise_value_next = out_t'(r_sat);
  end

  gnz_fade u_fade_x (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v0),
    .t         (fx0),
    .valid_out (vx3),
    .ease      (ex3)
  );

  gnz_fade u_fade_y (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v0),
    .t         (fy0),
    .valid_out (vy3),
    .ease      (ey3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= accept;
      v4   <= vx3;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    fx0   <= x_coord[FRAC_BITS-1:0];
    fy0   <= y_coord[FRAC_BITS-1:0];
    xi0   <= xsh[7:0];
    yi0   <= ysh[7:0];

    a00_1 <= corner_grad(hsh[1:0], dxp, dyp);
    a10_1 <= corner_grad(h10[1:0], dxm, dyp);
    a01_1 <= corner_grad(h01[1:0], dxp, dym);
    a11_1 <= corner_grad(h11[1:0], dxm, dym);

    a00_2 <= a00_1;
    a01_2 <= a01_1;
    d0_2  <= diff_t'(a10_1) - diff_t'(a00_1);
    d1_2  <= diff_t'(a11_1) - diff_t'(a01_1);

    a00_3 <= a00_2;
    a01_3 <= a01_2;
    d0_3  <= d0_2;
    d1_3  <= d1_2;

    p0_4  <= $signed({1'b0, ex3}) * d0_3;
    p1_4  <= $signed({1'b0, ex3}) * d1_3;
    a00_4 <= a00_3;
    a01_4 <= a01_3;
    ey4   <= ey3;

    lo5   <= diff_t'(a00_4) + diff_t'(p0_4 >>> FRAC_BITS);
    hi5   <= diff_t'(a01_4) + diff_t'(p1_4 >>> FRAC_BITS);
    ey5   <= ey4;

    lo6   <= lo5;
    dlh6  <= HW'(hi5) - HW'(lo5);
    ey6   <= ey5;

    lo7   <= lo6;
    q7    <= $signed({1'b0, ey6}) * dlh6;

    noise_value <= noise_value_next;
  end

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    vx3 == vy3)
    else $error("fade lanes out of step");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##9 done)
    else $error("accepted beat produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 9))
    else $error("result without an accepted beat");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((32'(noise_value) <= LIM) && (32'(noise_value) >= -LIM)))
    else $error("noise value out of range");

endmodule

`default_nettype wire

@@ tb/sv/gradient_noise_2d_top_tb.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d_top_tb: self-checking bench for the 2D gradient noise core
// Sends points to the core: first a directed set covering the coordinate
// extremes and all four gradient selections, then random points with random
// start gaps. A fixed-point model of the hash, quintic fade and bilinear blend
// predicts every noise value, and each done beat is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_noise_2d_top_tb;
  import gnz_pkg::*;

  localparam int RANDOM_POINTS = 1330;
  localparam int DRAIN_CYCLES  = 20;

  class noise_scoreboard;
    out_t expected_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    static function longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
    endfunction

    static function longint fade(longint t);
      longint t2;
      longint t3;
      longint inner;
      t2    = fx_mul(t, t);
      t3    = fx_mul(t2, t);
      inner = FADE_A * t - FADE_B * longint'(ONE);
      inner = fx_mul(t, inner) + FADE_C * longint'(ONE);
      return fx_mul(t3, inner);
    endfunction

    static function longint lerp(longint a, longint b, longint t);
      return a + fx_mul(t, b - a);
    endfunction

    static function longint gradient(int unsigned code, longint u, longint v);
      logic [1:0] sel;
      longint     p;
      longint     q;
      longint     r;
      sel = code[1:0];
      p   = sel[1] ? v : u;
      q   = sel[1] ? u : v;
      r   = sel[0] ? -p : p;
      r   = r + (sel[1] ? -2 * q : 2 * q);
      return r;
    endfunction

    static function out_t noise_at(coord_t x, coord_t y);
      int unsigned xi;
      int unsigned yi;
      int unsigned h;
      longint      fx;
      longint      fy;
      longint      ex;
      longint      ey;
      longint      lo;
      longint      hi;
      longint      r;
      longint      one_fx;
      one_fx = ONE;
      xi     = (x >> FRAC_BITS) & 255;
      yi     = (y >> FRAC_BITS) & 255;
      fx     = x & (ONE - 1);
      fy     = y & (ONE - 1);
      ex     = fade(fx);
      ey     = fade(fy);
      h      = (xi * HASH_X + yi * HASH_Y) & 255;
      lo     = lerp(gradient(h, fx, fy),
                    gradient(h + CORNER_10, fx - one_fx, fy), ex);
      hi     = lerp(gradient(h + CORNER_01, fx, fy - one_fx),
                    gradient(h + CORNER_11, fx - one_fx, fy - one_fx), ex);
      r      = lerp(lo, hi, ey);
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return out_t'(r);
    endfunction

    function void note_point(coord_t x, coord_t y);
      expected_q.push_back(noise_at(x, y));
    endfunction

    function void check_noise(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $error("noise_value: no beat expected, actual %0d", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("noise_value: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic   clk         = 1'b0;
  logic   rst         = 1'b1;
  logic   start       = 1'b0;
  coord_t x_coord     = '0;
  coord_t y_coord     = '0;
  logic   busy;
  logic   done;
  out_t   noise_value;

  noise_scoreboard sb;
  bit              burst;

  gradient_noise_2d_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .done        (done),
    .noise_value (noise_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_point(x_coord, y_coord);
    if (!rst && done) sb.check_noise(noise_value);
  end

  task automatic send_point(coord_t x, coord_t y, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (busy);
  endtask

  function automatic int draw_gap(int n);
    if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic coord_t rand_coord();
    coord_t c;
    c = coord_t'($urandom());
    case ($urandom_range(0, 7))
      0: c[FRAC_BITS-1:0] = '0;
      1: c[FRAC_BITS-1:0] = '1;
      2: c[FRAC_BITS-1:0] = frac_t'(1);
      3: c[FRAC_BITS-1:0] = frac_t'(ONE / 2);
      default: ;
    endcase
    return c;
  endfunction

  task automatic run_directed();
    coord_t xs[11] = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h00FFFF,
                       24'h000001, 24'h008000, 24'h010000, 24'hFF0000, 24'h00C000,
                       24'hFFFFFE};
    coord_t ys[11] = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h00FFFF,
                       24'h000001, 24'h008000, 24'h010000, 24'hFF8000, 24'h004000,
                       24'h7FFFFF};
    int     n;
    n = 0;
    foreach (xs[i]) begin
      send_point(xs[i], ys[i], draw_gap(n));
      n++;
    end
    for (int xi = 0; xi < 4; xi++) begin
      for (int yi = 0; yi < 2; yi++) begin
        send_point({xi[7:0], 16'h8000}, {yi[7:0], 16'h4000}, draw_gap(n));
        n++;
      end
    end
  endtask

  initial begin
    sb    = new();
    burst = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      send_point(rand_coord(), rand_coord(), draw_gap(n));
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
